// ===== hdl/multicart_bank_mapper_top_macros.svh =====
// assertion macros for the multicart bank mapper checker
// used only by multicart_bank_mapper_chk.sv; needs clk and rst_n in scope
`ifndef MULTICART_BANK_MAPPER_TOP_MACROS_SVH
`define MULTICART_BANK_MAPPER_TOP_MACROS_SVH

// general property check, disabled during reset
`define MCBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled signal holds its value into the next cycle
`define MCBM_ASSERT_HOLD(lbl, vld, stl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && (stl)) |=> $stable(sig)) else $error(msg);

`endif

// ===== hdl/mcbm_pkg.sv =====
// shared types and constants for the multicart bank mapper
// no dependencies
`default_nettype none

package mcbm_pkg;

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int BANK_W  = 4;
    localparam int PAD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    // address window of the outer registers, 0x6000-0x7fff
    localparam logic [2:0] OUTER_WIN = 3'b011;

    // outer prg register bits
    localparam int PRG_MODE16_BIT = 3;
    localparam int PRG_MIRROR_BIT = 4;
    localparam int PRG_LOCK_BIT   = 5;
    localparam int PRG_HIGH_BIT   = 6;

    // outer chr register bits
    localparam int CHR_NOLATCH_BIT = 4;
    localparam int CHR_ONELATCH_BIT = 5;

    localparam logic [PAD_W-1:0] PAD_LAST = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } item_t;

    typedef struct packed {
        logic [BANK_W-1:0] prg_bank_lo;
        logic [BANK_W-1:0] prg_bank_hi;
        logic [BANK_W-1:0] chr_bank;
        logic              mirror_vertical;
        logic              open_bus;
        logic              rom_read;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/multicart_bank_mapper_top.sv =====
// top level of the multicart bank mapper
// depends on mcbm_pkg, mcbm_in_stage, mcbm_core, mcbm_out_stage
//
//  channel   handshake            payload
//  input     in_valid / in_stall  cmd, addr, wdata
//  result    out_valid/out_stall  prg_bank_lo, prg_bank_hi, chr_bank,
//                                 mirror_vertical, open_bus, rom_read
//
// one item per cycle while neither side stalls; each item passes from acceptance to
// its result through the input register and then the result register
// rst_n clears all mapper registers and the pad setting
// a stall at the result side backs up into in_stall within the same cycle once
// both registers hold an item
`default_nettype none

module multicart_bank_mapper_top
    import mcbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [BANK_W-1:0]      prg_bank_lo,
    output logic [BANK_W-1:0]      prg_bank_hi,
    output logic [BANK_W-1:0]      chr_bank,
    output logic                   mirror_vertical,
    output logic                   open_bus,
    output logic                   rom_read
);

    logic    advance;
    logic    res_blocked;
    item_t   item;
    result_t result;
    result_t res_q;

    mcbm_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .addr        (addr),
        .wdata       (wdata),
        .res_blocked (res_blocked),
        .advance     (advance),
        .item        (item)
    );

    mcbm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    mcbm_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .result      (result),
        .res_blocked (res_blocked),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res_q       (res_q)
    );

    assign prg_bank_lo     = res_q.prg_bank_lo;
    assign prg_bank_hi     = res_q.prg_bank_hi;
    assign chr_bank        = res_q.chr_bank;
    assign mirror_vertical = res_q.mirror_vertical;
    assign open_bus        = res_q.open_bus;
    assign rom_read        = res_q.rom_read;

endmodule

`default_nettype wire

// ===== hdl/mcbm_in_stage.sv =====
// input register of the multicart bank mapper
// depends on mcbm_pkg
`default_nettype none

module mcbm_in_stage
    import mcbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              res_blocked,
    output logic                   advance,
    output item_t                  item
);

    logic  valid_reg;
    item_t item_reg;

    // the held item moves on whenever the result register can take it
    assign advance  = valid_reg & ~res_blocked;
    assign in_stall = valid_reg & res_blocked;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.cmd   <= cmd;
            item_reg.addr  <= addr;
            item_reg.wdata <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mcbm_core.sv =====
// mapper state and bank mapping logic
// depends on mcbm_pkg
`default_nettype none

module mcbm_core
    import mcbm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    output result_t    result
);

    logic [DATA_W-1:0] prg_reg, prg_next;
    logic [DATA_W-1:0] chr_reg, chr_next;
    logic [DATA_W-1:0] latch_reg, latch_next;
    logic [PAD_W-1:0]  pad_reg, pad_next;

    logic              upper;
    logic              outer_win;
    logic [BANK_W-1:0] prg_base;
    logic [BANK_W-1:0] chr_base;
    logic [1:0]        latch_mask;
    logic              obus_hit;

    always_comb
    begin
        upper     = item.addr[ADDR_W-1];
        outer_win = (item.addr[ADDR_W-1:ADDR_W-3] == OUTER_WIN);
        prg_next  = prg_reg;
        chr_next  = chr_reg;
        latch_next = latch_reg;
        pad_next  = pad_reg;
        obus_hit  = ((chr_reg[7:6] & pad_reg) != 2'd0);

        case (item.cmd)
            CMD_WRITE:
            begin
                if (upper)
                begin
                    latch_next = item.wdata;
                end
                else if (outer_win && !prg_reg[PRG_LOCK_BIT])
                begin
                    if (item.addr[0])
                        chr_next = item.wdata;
                    else
                        prg_next = item.wdata;
                end
            end
            CMD_RESET:
            begin
                pad_next   = (pad_reg >= PAD_LAST) ? '0 : pad_reg + 2'd1;
                prg_next   = '0;
                chr_next   = '0;
                latch_next = '0;
            end
            default:
            begin
            end
        endcase

        // mapping is taken from the state after the item
        prg_base = {prg_next[PRG_HIGH_BIT], prg_next[2:0]};
        chr_base = {prg_next[PRG_HIGH_BIT], chr_next[2:0]};

        if (chr_next[CHR_NOLATCH_BIT])
            latch_mask = 2'b00;
        else if (chr_next[CHR_ONELATCH_BIT])
            latch_mask = 2'b01;
        else
            latch_mask = 2'b11;

        if (prg_next[PRG_MODE16_BIT])
        begin
            result.prg_bank_lo = prg_base;
            result.prg_bank_hi = prg_base;
        end
        else
        begin
            result.prg_bank_lo = {prg_base[BANK_W-1:1], 1'b0};
            result.prg_bank_hi = {prg_base[BANK_W-1:1], 1'b1};
        end

        result.chr_bank = {chr_base[BANK_W-1:2],
                           (chr_base[1:0] & ~latch_mask) | (latch_next[1:0] & latch_mask)};
        result.mirror_vertical = ~prg_next[PRG_MIRROR_BIT];
        result.open_bus = (item.cmd == CMD_READ) && upper && obus_hit;
        result.rom_read = (item.cmd == CMD_READ) && upper && !obus_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_reg   <= '0;
            chr_reg   <= '0;
            latch_reg <= '0;
            pad_reg   <= '0;
        end
        else if (advance)
        begin
            prg_reg   <= prg_next;
            chr_reg   <= chr_next;
            latch_reg <= latch_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mcbm_out_stage.sv =====
// result register of the multicart bank mapper
// depends on mcbm_pkg
`default_nettype none

module mcbm_out_stage
    import mcbm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire result_t result,
    output logic         res_blocked,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      res_q
);

    logic    valid_reg;
    result_t res_reg;

    assign res_blocked = valid_reg & out_stall;
    assign out_valid   = valid_reg;
    assign res_q       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!res_blocked)
        begin
            valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/multicart_bank_mapper_chk.sv =====
// port-level checker for the multicart bank mapper, bound to the top level
// depends on mcbm_pkg and multicart_bank_mapper_top_macros.svh
`default_nettype none
`include "multicart_bank_mapper_top_macros.svh"

module multicart_bank_mapper_chk
    import mcbm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [BANK_W-1:0] prg_bank_lo,
    input wire logic [BANK_W-1:0] prg_bank_hi,
    input wire logic [BANK_W-1:0] chr_bank,
    input wire logic              open_bus,
    input wire logic              rom_read
);

    `MCBM_ASSERT_HOLD(a_out_hold, out_valid, out_stall, prg_bank_lo, "result moved while stalled")
    `MCBM_ASSERT(a_read_excl, out_valid |-> !(open_bus && rom_read), "open bus and rom read both set")
    `MCBM_ASSERT(a_prg_pair, (out_valid && prg_bank_lo != prg_bank_hi) |-> (!prg_bank_lo[0] && prg_bank_hi[0] && prg_bank_lo[BANK_W-1:1] == prg_bank_hi[BANK_W-1:1]), "32k prg pair malformed")
    `MCBM_ASSERT(a_high_bit, out_valid |-> (chr_bank[BANK_W-1] == prg_bank_lo[BANK_W-1]), "chr and prg high bank bits differ")

endmodule

bind multicart_bank_mapper_top multicart_bank_mapper_chk u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .prg_bank_lo (prg_bank_lo),
    .prg_bank_hi (prg_bank_hi),
    .chr_bank    (chr_bank),
    .open_bus    (open_bus),
    .rom_read    (rom_read)
);

`default_nettype wire
